/* hdl/touch_report_poll_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the touch report poll sequencer
// Shared property forms; each use stands on a line of its own.
// ----------------------------------------------------------------------------
`ifndef TOUCH_REPORT_POLL_SEQUENCER_DEFINES_SVH
`define TOUCH_REPORT_POLL_SEQUENCER_DEFINES_SVH

// Check that an antecedent always brings its consequent in the same cycle.
`define TRPS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition never holds.
`define TRPS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

/* hdl/trps_pkg.sv */
// ----------------------------------------------------------------------------
// trps_pkg
// Shared constants, codes and types of the touch report poll sequencer.
// ----------------------------------------------------------------------------
package trps_pkg;

   // Sizing
   localparam int REPORT_LIMIT = 34;
   localparam int POINT_CAP    = 5;
   localparam int MAX_RES      = 4;
   localparam int Q_DEPTH      = 4;

   localparam int STATUS_LEN  = 4;
   localparam int HDP_LEN     = 8;
   localparam int REPORT_HDR  = 4;
   localparam int POINT_BYTES = 6;

   localparam int IDX_W     = $clog2(REPORT_LIMIT + 1);
   localparam int PT_MAX    = REPORT_LIMIT / POINT_BYTES;
   localparam int PT_W      = $clog2(((PT_MAX > POINT_CAP) ? PT_MAX : POINT_CAP) + 1);
   localparam int RES_CNT_W = $clog2(MAX_RES + 1);
   localparam int RES_IDX_W = $clog2(MAX_RES);
   localparam int QPTR_W    = $clog2(Q_DEPTH);
   localparam int QCNT_W    = $clog2(Q_DEPTH + 1);
   localparam int RD_COUNT_W = 6;

   // Division by six of a report length minus header, valid up to 60
   localparam int DIV6_MUL    = 43;
   localparam int DIV6_SHIFT  = 8;
   localparam int DIV6_PROD_W = IDX_W + 6;

   // Input function codes
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_BYTE  = 2'd1;
   localparam logic [1:0] FUNC_FAIL  = 2'd2;

   // Result kinds
   localparam logic [2:0] KIND_WRITE   = 3'd0;
   localparam logic [2:0] KIND_READ    = 3'd1;
   localparam logic [2:0] KIND_POINT   = 3'd2;
   localparam logic [2:0] KIND_GESTURE = 3'd3;
   localparam logic [2:0] KIND_FINISH  = 3'd4;

   // Controller commands
   localparam logic [2:0] CMD_STATUS     = 3'd0;
   localparam logic [2:0] CMD_CLEAR_INT  = 3'd1;
   localparam logic [2:0] CMD_CPU_START  = 3'd2;
   localparam logic [2:0] CMD_POINT_MODE = 3'd3;
   localparam logic [2:0] CMD_START      = 3'd4;
   localparam logic [2:0] CMD_REPORT     = 3'd5;
   localparam logic [2:0] CMD_HDP_STATUS = 3'd6;

   // Status and report bit patterns
   localparam logic [7:0] HI_CPU_RESTART = 8'h40;
   localparam logic [7:0] HI_POINT_MODE  = 8'h20;
   localparam logic [7:0] HI_INT         = 8'h08;
   localparam logic [7:0] LO_INT         = 8'h08;
   localparam logic [7:0] LO_POINT       = 8'h01;
   localparam logic [7:0] LO_GESTURE     = 8'h02;
   localparam logic [7:0] TAG_POINT_MAX  = 8'h0A;
   localparam logic [7:0] TAG_GESTURE    = 8'hF6;
   localparam logic [7:0] HDP_CLEAR      = 8'h82;

   typedef struct packed {
      logic [2:0]            kind;
      logic [2:0]            cmd_code;
      logic [RD_COUNT_W-1:0] rd_count;
      logic [7:0]            point_id;
      logic [11:0]           x_pos;
      logic [11:0]           y_pos;
      logic [7:0]            pressure;
      logic [2:0]            gesture;
      logic                  failed;
   } result_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]             count;
      result_type [MAX_RES-1:0]         res;
   } bundle_type;

endpackage

/* hdl/trps_front.sv */
// ----------------------------------------------------------------------------
// trps_front
// Accepts input beats, tracks the poll phase and builds the result bundle.
// ----------------------------------------------------------------------------
`include "touch_report_poll_sequencer_defines.svh"

module trps_front import trps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_func,
   input  logic [7:0]       req_rx_byte,
   input  logic             q_full,
   output logic             push_valid,
   output bundle_type       push_data
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_STATUS,
      PH_REPORT,
      PH_HDPSTAT,
      PH_DRAIN
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]       stat_lo_ff, stat_lo_in;
   logic [7:0]       stat_hi_ff, stat_hi_in;
   logic [15:0]      rpt_len_ff, rpt_len_in;
   logic [7:0]       frame_tag_ff, frame_tag_in;
   logic [31:0]      point_bytes_ff, point_bytes_in;
   logic [23:0]      drain_stat_ff, drain_stat_in;
   logic [PT_W-1:0]  pts_emit_ff, pts_emit_in;
   logic [2:0]       pos_ff, pos_in;
   logic [PT_W-1:0]  pt_ff, pt_in;

   logic             item_acc;
   logic [IDX_W:0]   idx_p1;
   logic [IDX_W-1:0] rel_len;
   logic [DIV6_PROD_W-1:0] prod;
   logic [DIV6_PROD_W-1:0] quot;
   logic [PT_W-1:0]  pts_calc;
   logic [7:0]       lo_v;
   logic [7:0]       hi_v;
   logic [15:0]      len_v;
   logic [7:0]       hdp_code;
   logic [15:0]      hdp_remain;
   bundle_type       bundle;

   function automatic result_type mk_cmd(logic [2:0] kind, logic [2:0] cmd,
                                         logic [RD_COUNT_W-1:0] len);
      result_type r;
      r          = '0;
      r.kind     = kind;
      r.cmd_code = cmd;
      r.rd_count = len;
      return r;
   endfunction

   function automatic result_type mk_finish(logic f);
      result_type r;
      r        = '0;
      r.kind   = KIND_FINISH;
      r.failed = f;
      return r;
   endfunction

   function automatic bundle_type add_res(bundle_type b, result_type r);
      bundle_type o;
      o = b;
      o.res[b.count[RES_IDX_W-1:0]] = r;
      o.count = b.count + RES_CNT_W'(1);
      return o;
   endfunction

   assign item_acc  = req_valid && !req_stall;
   assign req_stall = q_full;
   assign idx_p1    = {1'b0, byte_index_ff} + (IDX_W + 1)'(1);

   // Point count: (length - header) / 6 by reciprocal, capped
   assign rel_len  = rpt_len_ff[IDX_W-1:0] - IDX_W'(REPORT_HDR);
   assign prod     = DIV6_PROD_W'(rel_len) * DIV6_PROD_W'(DIV6_MUL);
   assign quot     = prod >> DIV6_SHIFT;
   assign pts_calc = (quot > DIV6_PROD_W'(POINT_CAP)) ? PT_W'(POINT_CAP) : quot[PT_W-1:0];

   assign hdp_code   = drain_stat_ff[23:16];
   assign hdp_remain = drain_stat_ff[15:0];

   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      stat_lo_in     = stat_lo_ff;
      stat_hi_in     = stat_hi_ff;
      rpt_len_in     = rpt_len_ff;
      frame_tag_in   = frame_tag_ff;
      point_bytes_in = point_bytes_ff;
      drain_stat_in  = drain_stat_ff;
      pts_emit_in    = pts_emit_ff;
      pos_in         = pos_ff;
      pt_in          = pt_ff;
      lo_v           = stat_lo_ff;
      hi_v           = stat_hi_ff;
      len_v          = rpt_len_ff;
      bundle         = '0;
      if (item_acc) begin
         unique case (req_func)
            FUNC_START: begin
               phase_in       = PH_STATUS;
               byte_index_in  = '0;
               stat_lo_in     = '0;
               stat_hi_in     = '0;
               rpt_len_in     = '0;
               frame_tag_in   = '0;
               point_bytes_in = '0;
               drain_stat_in  = '0;
               pts_emit_in    = '0;
               pos_in         = '0;
               pt_in          = '0;
               bundle = add_res(bundle, mk_cmd(KIND_READ, CMD_STATUS,
                                               RD_COUNT_W'(STATUS_LEN)));
            end
            FUNC_FAIL: begin
               if (phase_ff != PH_IDLE) begin
                  bundle        = add_res(bundle, mk_finish(1'b1));
                  phase_in      = PH_IDLE;
                  byte_index_in = '0;
               end
            end
            FUNC_BYTE: begin
               unique case (phase_ff)
                  PH_STATUS: begin
                     priority if (byte_index_ff == IDX_W'(0)) begin
                        lo_v = req_rx_byte;
                     end else if (byte_index_ff == IDX_W'(1)) begin
                        hi_v = req_rx_byte;
                     end else if (byte_index_ff == IDX_W'(2)) begin
                        len_v = {8'h00, req_rx_byte};
                     end else begin
                        len_v = rpt_len_ff | {req_rx_byte, 8'h00};
                     end
                     stat_lo_in    = lo_v;
                     stat_hi_in    = hi_v;
                     rpt_len_in    = len_v;
                     byte_index_in = idx_p1[IDX_W-1:0];
                     if (byte_index_ff == IDX_W'(STATUS_LEN - 1)) begin
                        // Decide on the complete status word
                        phase_in      = PH_IDLE;
                        byte_index_in = '0;
                        priority if ((hi_v & HI_CPU_RESTART) != '0) begin
                           bundle = add_res(bundle, mk_cmd(KIND_WRITE, CMD_CLEAR_INT, '0));
                           bundle = add_res(bundle, mk_cmd(KIND_WRITE, CMD_CPU_START, '0));
                           bundle = add_res(bundle, mk_finish(1'b0));
                        end else if ((hi_v & HI_POINT_MODE) != '0) begin
                           bundle = add_res(bundle, mk_cmd(KIND_WRITE, CMD_POINT_MODE, '0));
                           bundle = add_res(bundle, mk_cmd(KIND_WRITE, CMD_START, '0));
                           bundle = add_res(bundle, mk_cmd(KIND_WRITE, CMD_CLEAR_INT, '0));
                           bundle = add_res(bundle, mk_finish(1'b0));
                        end else if (((hi_v & HI_INT) != '0) && (len_v == '0)) begin
                           bundle = add_res(bundle, mk_cmd(KIND_WRITE, CMD_CLEAR_INT, '0));
                           bundle = add_res(bundle, mk_finish(1'b0));
                        end else if ((lo_v & (LO_POINT | LO_GESTURE)) == '0) begin
                           if (((hi_v & HI_INT) != '0) && ((lo_v & LO_INT) != '0)) begin
                              bundle = add_res(bundle,
                                               mk_cmd(KIND_WRITE, CMD_CLEAR_INT, '0));
                           end
                           bundle = add_res(bundle, mk_finish(1'b0));
                        end else if ((len_v > 16'(REPORT_LIMIT)) ||
                                     (len_v < 16'(REPORT_HDR))) begin
                           bundle = add_res(bundle, mk_finish(1'b0));
                        end else begin
                           bundle = add_res(bundle, mk_cmd(KIND_READ, CMD_REPORT,
                                                           len_v[RD_COUNT_W-1:0]));
                           phase_in       = PH_REPORT;
                           frame_tag_in   = '0;
                           point_bytes_in = '0;
                           pts_emit_in    = '0;
                           pos_in         = '0;
                           pt_in          = '0;
                        end
                     end
                  end
                  PH_REPORT: begin
                     if (byte_index_ff == IDX_W'(REPORT_HDR)) begin
                        frame_tag_in = req_rx_byte;
                        pts_emit_in  = ((req_rx_byte <= TAG_POINT_MAX) &&
                                        ((stat_lo_ff & LO_POINT) != '0)) ? pts_calc : '0;
                     end
                     if ((byte_index_ff == IDX_W'(REPORT_HDR + 2)) &&
                         (frame_tag_ff == TAG_GESTURE) &&
                         ((stat_lo_ff & LO_GESTURE) != '0)) begin
                        bundle = add_res(bundle, '{kind: KIND_GESTURE, cmd_code: '0,
                                                   rd_count: '0, point_id: '0,
                                                   x_pos: '0, y_pos: '0, pressure: '0,
                                                   gesture: req_rx_byte[2:0],
                                                   failed: 1'b0});
                     end
                     if (byte_index_ff >= IDX_W'(REPORT_HDR)) begin
                        if (pos_ff < 3'd4) begin
                           point_bytes_in[8*pos_ff[1:0] +: 8] = req_rx_byte;
                        end else if ((pos_ff == 3'd4) && (pt_ff < pts_emit_ff)) begin
                           bundle = add_res(bundle, '{kind: KIND_POINT, cmd_code: '0,
                              rd_count: '0, point_id: point_bytes_ff[7:0],
                              x_pos: {point_bytes_ff[31:28], point_bytes_ff[15:8]},
                              y_pos: {point_bytes_ff[27:24], point_bytes_ff[23:16]},
                              pressure: req_rx_byte, gesture: '0, failed: 1'b0});
                        end
                        if (pos_ff == 3'(POINT_BYTES - 1)) begin
                           pos_in = '0;
                           pt_in  = pt_ff + PT_W'(1);
                        end else begin
                           pos_in = pos_ff + 3'd1;
                        end
                     end
                     byte_index_in = idx_p1[IDX_W-1:0];
                     if (16'(idx_p1) >= rpt_len_ff) begin
                        bundle = add_res(bundle, mk_cmd(KIND_READ, CMD_HDP_STATUS,
                                                        RD_COUNT_W'(HDP_LEN)));
                        phase_in      = PH_HDPSTAT;
                        byte_index_in = '0;
                     end
                  end
                  PH_HDPSTAT: begin
                     if (byte_index_ff == IDX_W'(2)) begin
                        drain_stat_in[7:0] = req_rx_byte;
                     end else if (byte_index_ff == IDX_W'(3)) begin
                        drain_stat_in[15:8] = req_rx_byte;
                     end else if (byte_index_ff == IDX_W'(5)) begin
                        drain_stat_in[23:16] = req_rx_byte;
                     end
                     byte_index_in = idx_p1[IDX_W-1:0];
                     if (byte_index_ff == IDX_W'(HDP_LEN - 1)) begin
                        priority if (hdp_code == HDP_CLEAR) begin
                           bundle = add_res(bundle, mk_cmd(KIND_WRITE, CMD_CLEAR_INT, '0));
                           bundle = add_res(bundle, mk_finish(1'b0));
                           phase_in      = PH_IDLE;
                           byte_index_in = '0;
                        end else if ((hdp_code != '0) || (hdp_remain == '0) ||
                                     (hdp_remain > 16'(REPORT_LIMIT))) begin
                           bundle = add_res(bundle, mk_finish(1'b0));
                           phase_in      = PH_IDLE;
                           byte_index_in = '0;
                        end else begin
                           rpt_len_in = hdp_remain;
                           bundle = add_res(bundle, mk_cmd(KIND_READ, CMD_REPORT,
                                                           hdp_remain[RD_COUNT_W-1:0]));
                           phase_in      = PH_DRAIN;
                           byte_index_in = '0;
                        end
                     end
                  end
                  PH_DRAIN: begin
                     byte_index_in = idx_p1[IDX_W-1:0];
                     if (16'(idx_p1) >= rpt_len_ff) begin
                        bundle = add_res(bundle, mk_cmd(KIND_READ, CMD_HDP_STATUS,
                                                        RD_COUNT_W'(HDP_LEN)));
                        phase_in      = PH_HDPSTAT;
                        byte_index_in = '0;
                     end
                  end
                  default: begin
                     // Stray byte while idle: drop
                  end
               endcase
            end
            default: begin
               // Unknown function: drop
            end
         endcase
      end
   end

   assign push_valid = item_acc && (bundle.count != '0);
   assign push_data  = bundle;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         byte_index_ff  <= '0;
         stat_lo_ff     <= '0;
         stat_hi_ff     <= '0;
         rpt_len_ff     <= '0;
         frame_tag_ff   <= '0;
         point_bytes_ff <= '0;
         drain_stat_ff  <= '0;
         pts_emit_ff    <= '0;
         pos_ff         <= '0;
         pt_ff          <= '0;
      end else begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         stat_lo_ff     <= stat_lo_in;
         stat_hi_ff     <= stat_hi_in;
         rpt_len_ff     <= rpt_len_in;
         frame_tag_ff   <= frame_tag_in;
         point_bytes_ff <= point_bytes_in;
         drain_stat_ff  <= drain_stat_in;
         pts_emit_ff    <= pts_emit_in;
         pos_ff         <= pos_in;
         pt_ff          <= pt_in;
      end
   end

   `TRPS_ASSERT_IMPLY(a_idle_index, clock, reset, phase_ff == PH_IDLE, byte_index_ff == '0, "byte index not cleared while idle")
   `TRPS_ASSERT_IMPLY(a_push_nonempty, clock, reset, push_valid, (bundle.count != '0) && (bundle.count <= RES_CNT_W'(MAX_RES)), "pushed bundle count out of range")

endmodule

/* hdl/trps_fifo.sv */
// ----------------------------------------------------------------------------
// trps_fifo
// Short bundle queue between the front and the back.
// ----------------------------------------------------------------------------
`include "touch_report_poll_sequencer_defines.svh"

module trps_fifo import trps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  bundle_type  push_data,
   output logic        full,
   output logic        head_valid,
   output bundle_type  head_data,
   input  logic        pop
);

   bundle_type        mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;

   assign full       = (cnt_ff == QCNT_W'(Q_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         cnt_ff <= cnt_ff + QCNT_W'(push_valid) - QCNT_W'(pop);
      end
   end

   `TRPS_ASSERT_NEVER(a_push_full, clock, reset, push_valid && full, "push into full queue")
   `TRPS_ASSERT_NEVER(a_pop_empty, clock, reset, pop && !head_valid, "pop from empty queue")

endmodule

/* hdl/trps_back.sv */
// ----------------------------------------------------------------------------
// trps_back
// Walks the head bundle one result per cycle, unless stalled, into the output register.
// ----------------------------------------------------------------------------
`include "touch_report_poll_sequencer_defines.svh"

module trps_back import trps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  bundle_type  head_data,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output result_type  rsp_res,
   output logic        rsp_last
);

   logic [RES_IDX_W-1:0] sel_ff;
   logic                 valid_ff;
   result_type           res_ff;
   logic                 last_ff;
   logic                 load;
   logic                 is_last;

   assign load    = head_valid && (!valid_ff || !rsp_stall);
   assign is_last = ((RES_CNT_W'(sel_ff) + RES_CNT_W'(1)) == head_data.count);
   assign pop     = load && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            sel_ff   <= is_last ? '0 : sel_ff + RES_IDX_W'(1);
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Payload: advance only on a load, hold while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head_data.res[sel_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;
   assign rsp_last  = last_ff;

   `TRPS_ASSERT_IMPLY(a_sel_in_bundle, clock, reset, head_valid, RES_CNT_W'(sel_ff) < head_data.count, "result select beyond bundle")

endmodule

/* hdl/touch_report_poll_sequencer.sv */
// ----------------------------------------------------------------------------
// touch_report_poll_sequencer
// Byte-driven sequencer for one poll of a capacitive touch controller.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): one beat is a start, one received
//   response byte, or a bus failure notice. The block stalls requests only when
//   its bundle queue (four entries) is full; otherwise it takes one beat every
//   cycle.
//   Response channel (rsp_valid / rsp_stall): a beat is a bus command, a touch
//   point, a gesture or a poll finish. One request beat yields zero to four
//   response beats, the final one carrying rsp_last.
//   The results of a request are written into the queue and then loaded into
//   the output register; further responses of the same request follow one
//   per cycle while rsp_stall is low.
//   Throughput is one response beat per cycle while rsp_stall is low, set by
//   the output register of the back end.
//   Reset (synchronous, active high) returns the poll to idle and empties the
//   queue; no response is pending afterwards.
//   When the receiver stalls, the output beat holds, the queue fills, and only
//   then does req_stall rise.
// ----------------------------------------------------------------------------
module touch_report_poll_sequencer import trps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_cmd_code,
   output logic [5:0]  rsp_rd_count,
   output logic [7:0]  rsp_point_id,
   output logic [11:0] rsp_x_pos,
   output logic [11:0] rsp_y_pos,
   output logic [7:0]  rsp_pressure,
   output logic [2:0]  rsp_gesture,
   output logic        rsp_failed,
   output logic        rsp_last
);

   logic       q_full;
   logic       push_valid;
   bundle_type push_data;
   logic       head_valid;
   bundle_type head_data;
   logic       pop;
   result_type rsp_res;

   // Front: classify each request beat and build its result bundle
   trps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   // Queue: decouple request acceptance from response delivery
   trps_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // Back: emit bundled results one beat at a time
   trps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_res    (rsp_res),
      .rsp_last   (rsp_last)
   );

   assign rsp_kind     = rsp_res.kind;
   assign rsp_cmd_code = rsp_res.cmd_code;
   assign rsp_rd_count = rsp_res.rd_count;
   assign rsp_point_id = rsp_res.point_id;
   assign rsp_x_pos    = rsp_res.x_pos;
   assign rsp_y_pos    = rsp_res.y_pos;
   assign rsp_pressure = rsp_res.pressure;
   assign rsp_gesture  = rsp_res.gesture;
   assign rsp_failed   = rsp_res.failed;

endmodule

/* bench/trps_poll_checker.sv */
// ----------------------------------------------------------------------------
// trps_poll_checker
// Watches both channels of the touch report poll sequencer, predicts the
// response beats of every accepted request beat and compares them in order.
// ----------------------------------------------------------------------------
module trps_poll_checker import trps_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [2:0]  rsp_cmd_code,
   input  logic [5:0]  rsp_rd_count,
   input  logic [7:0]  rsp_point_id,
   input  logic [11:0] rsp_x_pos,
   input  logic [11:0] rsp_y_pos,
   input  logic [7:0]  rsp_pressure,
   input  logic [2:0]  rsp_gesture,
   input  logic        rsp_failed,
   input  logic        rsp_last,
   output int          error_count,
   output int          due_count,
   output int          beats_checked,
   output int          points_seen,
   output int          gestures_seen,
   output int          failed_polls
);

   localparam int GESTURE_BYTE = 6;
   localparam int HDP_REMAIN_LO = 2;
   localparam int HDP_REMAIN_HI = 3;
   localparam int HDP_CODE = 5;

   typedef enum logic [2:0] {
      POLL_IDLE,
      POLL_STATUS,
      POLL_REPORT,
      POLL_HDP,
      POLL_DRAIN
   } poll_phase_type;

   typedef struct packed {
      result_type res;
      logic       last;
   } due_beat_type;

   // poll state
   poll_phase_type phase;
   int          byte_idx;
   logic [7:0]  sts_lo;
   logic [7:0]  sts_hi;
   logic [15:0] rpt_len;
   logic [7:0]  frame_tag;
   logic [31:0] pt_bytes;
   logic [23:0] hdp_bytes;
   int          pts_left;

   result_type   step_beats[$];
   due_beat_type due_beats[$];

   function automatic void clear_poll();
      phase     = POLL_IDLE;
      byte_idx  = 0;
      sts_lo    = '0;
      sts_hi    = '0;
      rpt_len   = '0;
      frame_tag = '0;
      pt_bytes  = '0;
      hdp_bytes = '0;
      pts_left  = 0;
   endfunction

   function automatic result_type cmd_beat(logic [2:0] kind, logic [2:0] cmd,
                                           logic [5:0] len);
      result_type r;
      r          = '0;
      r.kind     = kind;
      r.cmd_code = cmd;
      r.rd_count = len;
      return r;
   endfunction

   function automatic void emit(result_type r);
      if (step_beats.size() < MAX_RES) step_beats.push_back(r);
   endfunction

   function automatic void end_poll(logic fail);
      result_type r;
      r        = cmd_beat(KIND_FINISH, CMD_STATUS, '0);
      r.failed = fail;
      emit(r);
      phase    = POLL_IDLE;
      byte_idx = 0;
   endfunction

   function automatic void ask_hdp_status();
      emit(cmd_beat(KIND_READ, CMD_HDP_STATUS, 6'(HDP_LEN)));
      phase    = POLL_HDP;
      byte_idx = 0;
   endfunction

   function automatic void decide_status();
      if ((sts_hi & HI_CPU_RESTART) != 0) begin
         emit(cmd_beat(KIND_WRITE, CMD_CLEAR_INT, '0));
         emit(cmd_beat(KIND_WRITE, CMD_CPU_START, '0));
         end_poll(1'b0);
      end else if ((sts_hi & HI_POINT_MODE) != 0) begin
         emit(cmd_beat(KIND_WRITE, CMD_POINT_MODE, '0));
         emit(cmd_beat(KIND_WRITE, CMD_START, '0));
         emit(cmd_beat(KIND_WRITE, CMD_CLEAR_INT, '0));
         end_poll(1'b0);
      end else if ((sts_hi & HI_INT) != 0 && rpt_len == 0) begin
         emit(cmd_beat(KIND_WRITE, CMD_CLEAR_INT, '0));
         end_poll(1'b0);
      end else if ((sts_lo & (LO_POINT | LO_GESTURE)) == 0) begin
         if ((sts_hi & HI_INT) != 0 && (sts_lo & LO_INT) != 0)
            emit(cmd_beat(KIND_WRITE, CMD_CLEAR_INT, '0));
         end_poll(1'b0);
      end else if (rpt_len > REPORT_LIMIT || rpt_len < REPORT_HDR) begin
         end_poll(1'b0);
      end else begin
         emit(cmd_beat(KIND_READ, CMD_REPORT, rpt_len[5:0]));
         phase     = POLL_REPORT;
         byte_idx  = 0;
         frame_tag = '0;
         pt_bytes  = '0;
         pts_left  = 0;
      end
   endfunction

   function automatic void take_report_byte(logic [7:0] b);
      result_type r;
      int pos;
      int pt;
      if (byte_idx == REPORT_HDR) begin
         frame_tag = b;
         pts_left  = 0;
         if (b <= TAG_POINT_MAX && (sts_lo & LO_POINT) != 0) begin
            pts_left = (int'(rpt_len) - REPORT_HDR) / POINT_BYTES;
            if (pts_left > POINT_CAP) pts_left = POINT_CAP;
         end
      end
      if (byte_idx == GESTURE_BYTE && frame_tag == TAG_GESTURE &&
          (sts_lo & LO_GESTURE) != 0) begin
         r         = cmd_beat(KIND_GESTURE, CMD_STATUS, '0);
         r.gesture = b[2:0];
         emit(r);
      end
      if (byte_idx >= REPORT_HDR) begin
         pos = (byte_idx - REPORT_HDR) % POINT_BYTES;
         pt  = (byte_idx - REPORT_HDR) / POINT_BYTES;
         if (pos < 4) begin
            pt_bytes[8*pos +: 8] = b;
         end else if (pos == 4 && pt < pts_left) begin
            r          = cmd_beat(KIND_POINT, CMD_STATUS, '0);
            r.point_id = pt_bytes[7:0];
            r.x_pos    = {pt_bytes[31:28], pt_bytes[15:8]};
            r.y_pos    = {pt_bytes[27:24], pt_bytes[23:16]};
            r.pressure = b;
            emit(r);
         end
      end
      byte_idx++;
      if (byte_idx >= rpt_len) ask_hdp_status();
   endfunction

   function automatic void take_hdp_byte(logic [7:0] b);
      logic [7:0]  code;
      logic [15:0] remain;
      if (byte_idx == HDP_REMAIN_LO) hdp_bytes[7:0] = b;
      else if (byte_idx == HDP_REMAIN_HI) hdp_bytes[15:8] = b;
      else if (byte_idx == HDP_CODE) hdp_bytes[23:16] = b;
      byte_idx++;
      if (byte_idx == HDP_LEN) begin
         code   = hdp_bytes[23:16];
         remain = hdp_bytes[15:0];
         if (code == HDP_CLEAR) begin
            emit(cmd_beat(KIND_WRITE, CMD_CLEAR_INT, '0));
            end_poll(1'b0);
         end else if (code != 0 || remain == 0 || remain > REPORT_LIMIT) begin
            end_poll(1'b0);
         end else begin
            rpt_len = remain;
            emit(cmd_beat(KIND_READ, CMD_REPORT, remain[5:0]));
            phase    = POLL_DRAIN;
            byte_idx = 0;
         end
      end
   endfunction

   // Work out every response beat that one request beat causes and queue them.
   function automatic void predict_poll_step(logic [1:0] func, logic [7:0] b);
      due_beat_type d;
      step_beats.delete();
      case (func)
         FUNC_START: begin
            clear_poll();
            emit(cmd_beat(KIND_READ, CMD_STATUS, 6'(STATUS_LEN)));
            phase = POLL_STATUS;
         end
         FUNC_FAIL: begin
            if (phase != POLL_IDLE) end_poll(1'b1);
         end
         FUNC_BYTE: begin
            case (phase)
               POLL_STATUS: begin
                  if (byte_idx == 0) sts_lo = b;
                  else if (byte_idx == 1) sts_hi = b;
                  else if (byte_idx == 2) rpt_len = {8'h00, b};
                  else rpt_len[15:8] = b;
                  byte_idx++;
                  if (byte_idx >= STATUS_LEN) decide_status();
               end
               POLL_REPORT: take_report_byte(b);
               POLL_HDP:    take_hdp_byte(b);
               POLL_DRAIN: begin
                  byte_idx++;
                  if (byte_idx >= rpt_len) ask_hdp_status();
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      foreach (step_beats[i]) begin
         d.res  = step_beats[i];
         d.last = (i == step_beats.size() - 1);
         due_beats.push_back(d);
      end
   endfunction

   function automatic void check_field(string name, int unsigned want,
                                       int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      due_beat_type d;
      if (reset) begin
         clear_poll();
         due_beats.delete();
      end else begin
         if (req_valid && !req_stall) predict_poll_step(req_func, req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (due_beats.size() == 0) begin
               $error("response beat with nothing due: kind %0d", rsp_kind);
               error_count++;
            end else begin
               d = due_beats.pop_front();
               check_field("kind",     d.res.kind,     rsp_kind);
               check_field("cmd_code", d.res.cmd_code, rsp_cmd_code);
               check_field("rd_count", d.res.rd_count, rsp_rd_count);
               check_field("point_id", d.res.point_id, rsp_point_id);
               check_field("x_pos",    d.res.x_pos,    rsp_x_pos);
               check_field("y_pos",    d.res.y_pos,    rsp_y_pos);
               check_field("pressure", d.res.pressure, rsp_pressure);
               check_field("gesture",  d.res.gesture,  rsp_gesture);
               check_field("failed",   d.res.failed,   rsp_failed);
               check_field("last",     d.last,         rsp_last);
               if (d.res.kind == KIND_POINT) points_seen++;
               if (d.res.kind == KIND_GESTURE) gestures_seen++;
               if (d.res.kind == KIND_FINISH && d.res.failed) failed_polls++;
            end
         end
      end
      due_count = due_beats.size();
   end

endmodule

/* bench/tb_touch_report_poll_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_touch_report_poll_sequencer
// Drives polls of the touch report poll sequencer: a few hand-picked status
// words and ignored beats first, then random polls that walk the full flow
// (status, report with points or gesture, report status, drain) with stray
// beats mixed in. A checker beside the block predicts every response beat.
// ----------------------------------------------------------------------------
module tb_touch_report_poll_sequencer;
   import trps_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int IDLE_PCT      = 9;
   localparam int ITEM_TARGET   = 170;
   localparam int DRAIN_ROUNDS  = 3;
   localparam int SETTLE_CYCLES = 20;
   localparam int WAIT_LIMIT    = 5000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func    = FUNC_START;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [2:0]  rsp_kind;
   logic [2:0]  rsp_cmd_code;
   logic [5:0]  rsp_rd_count;
   logic [7:0]  rsp_point_id;
   logic [11:0] rsp_x_pos;
   logic [11:0] rsp_y_pos;
   logic [7:0]  rsp_pressure;
   logic [2:0]  rsp_gesture;
   logic        rsp_failed;
   logic        rsp_last;

   int error_count;
   int due_count;
   int beats_checked;
   int points_seen;
   int gestures_seen;
   int failed_polls;

   bit quiet = 1'b0;   // no idling on either side while set
   bit noisy = 1'b0;   // mix stray beats into the byte stream while set
   int sent  = 0;
   int polls_run = 0;

   always #2 clock = ~clock;

   touch_report_poll_sequencer u_dut (.*);

   trps_poll_checker u_checker (.*);

   // Stall the response side now and then, except in the quiet stretch.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   // Present one request beat and hold it until the block takes it. Random
   // idle cycles go in front of the beat; valid stays high between
   // back-to-back beats.
   task automatic send_beat(input logic [1:0] func, input logic [7:0] data);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_rx_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   // Send one response byte; in the noisy part, occasionally slip in a bus
   // failure, an abandoning start or an unused function code ahead of it.
   // Drop the rest of the poll once the beat budget is spent.
   task automatic send_data(input logic [7:0] data);
      int roll;
      if (sent >= ITEM_TARGET) return;
      roll = noisy ? $urandom_range(199) : 199;
      if (roll == 0) send_beat(FUNC_FAIL, 8'($urandom_range(255)));
      else if (roll == 1) send_beat(FUNC_START, 8'($urandom_range(255)));
      else if (roll < 5) send_beat(FUNC_UNUSED, 8'($urandom_range(255)));
      send_beat(FUNC_BYTE, data);
   endtask

   // Start a poll and answer the status read with the given word.
   task automatic start_status(input logic [7:0] lo, input logic [7:0] hi,
                               input logic [15:0] len);
      send_beat(FUNC_START, 8'($urandom_range(255)));
      send_data(lo);
      send_data(hi);
      send_data(len[7:0]);
      send_data(len[15:8]);
   endtask

   // One random poll, shaped so that most of them get through to a report.
   task automatic run_random_poll();
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [7:0]  tag;
      logic [7:0]  code;
      logic [15:0] len;
      logic [15:0] remain;
      int          pick;
      lo = 8'($urandom_range(255));
      if ($urandom_range(99) < 80) lo = lo | 8'($urandom_range(1, 3));
      pick = $urandom_range(99);
      hi = 8'($urandom_range(255));
      if (pick < 70) hi = hi & ~(HI_CPU_RESTART | HI_POINT_MODE | HI_INT);
      else if (pick < 80) hi = hi & ~(HI_CPU_RESTART | HI_POINT_MODE);
      pick = $urandom_range(99);
      if (pick < 75) len = 16'($urandom_range(REPORT_HDR, 16));
      else if (pick < 85) len = 16'($urandom_range(17, REPORT_LIMIT));
      else if (pick < 92) len = 16'($urandom_range(REPORT_HDR - 1));
      else len = 16'($urandom_range(16'hFFFF));
      start_status(lo, hi, len);

      // Drop out unless the status word asks for a report.
      if ((hi & (HI_CPU_RESTART | HI_POINT_MODE)) != 0) return;
      if ((hi & HI_INT) != 0 && len == 0) return;
      if ((lo & (LO_POINT | LO_GESTURE)) == 0) return;
      if (len < REPORT_HDR || len > REPORT_LIMIT) return;

      pick = $urandom_range(99);
      if (pick < 40) tag = 8'($urandom_range(TAG_POINT_MAX));
      else if (pick < 70) tag = TAG_GESTURE;
      else tag = 8'($urandom_range(255));
      for (int i = 0; i < len; i++)
         send_data((i == REPORT_HDR) ? tag : 8'($urandom_range(255)));

      // Answer report status reads; drain whatever the controller still holds.
      for (int round = 0; round < DRAIN_ROUNDS; round++) begin
         pick = $urandom_range(99);
         if (pick < 30) code = HDP_CLEAR;
         else if (pick < 75) code = 8'h00;
         else code = 8'($urandom_range(255));
         if (round == DRAIN_ROUNDS - 1) code = HDP_CLEAR;
         pick = $urandom_range(99);
         if (pick < 55) remain = 16'($urandom_range(1, 12));
         else if (pick < 70) remain = 16'($urandom_range(13, REPORT_LIMIT));
         else if (pick < 85) remain = 16'h0000;
         else remain = 16'($urandom_range(16'hFFFF));
         for (int i = 0; i < HDP_LEN; i++) begin
            if (i == 2) send_data(remain[7:0]);
            else if (i == 3) send_data(remain[15:8]);
            else if (i == 5) send_data(code);
            else send_data(8'($urandom_range(255)));
         end
         if (code != 8'h00 || remain == 0 || remain > REPORT_LIMIT) break;
         for (int i = 0; i < remain; i++) send_data(8'($urandom_range(255)));
      end
   endtask

   initial begin : stimulus
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Ignored beats while idle: failure, stray byte, unused function.
      send_beat(FUNC_FAIL, 8'h00);
      send_beat(FUNC_BYTE, 8'hFF);
      send_beat(FUNC_UNUSED, 8'hAA);
      // Write-only outcomes: CPU restart, point mode (all bits up but CPU restart), clear int.
      start_status(8'h00, HI_CPU_RESTART, 16'h0000);
      start_status(8'hFF, 8'hBF, 16'hFFFF);
      start_status(8'h00, HI_INT, 16'h0000);
      // Report length below the header.
      start_status(LO_POINT, 8'h00, 16'h0003);
      // Abandon a poll with a fresh start, then fail the new one.
      send_beat(FUNC_START, 8'h5A);
      send_beat(FUNC_BYTE, 8'h01);
      send_beat(FUNC_START, 8'h00);
      send_beat(FUNC_FAIL, 8'hFF);

      // Random polls, with a stretch of full-rate traffic in the middle.
      noisy = 1'b1;
      while (sent < ITEM_TARGET) begin
         quiet = (polls_run >= 4 && polls_run < 8);
         run_random_poll();
         polls_run++;
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // Wait for every due beat, then let the pipe settle.
      n = 0;
      while (due_count != 0 && n < WAIT_LIMIT) begin
         @(negedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (due_count != 0) $error("%0d response beats never arrived", due_count);

      $display("Sent %0d request beats over %0d random polls; checked %0d response beats.",
               sent, polls_run, beats_checked);
      $display("Decoded %0d touch points and %0d gestures; %0d polls ended on a bus failure.",
               points_seen, gestures_seen, failed_polls);
      if (error_count == 0 && due_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Guard against a hang anywhere in the run.
   initial begin : watchdog
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
